// File: rtl/bitmap_glyph_blitter_macros.svh
// Assertion macros shared by the checker of the glyph blitter.
// No dependencies; each macro expands to one labeled concurrent assertion.
`ifndef BITMAP_GLYPH_BLITTER_MACROS_SVH
`define BITMAP_GLYPH_BLITTER_MACROS_SVH

// The condition holds in the cycle after the trigger.
`define BGB_ASSERT_NEXT(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("glyph blitter assertion violated");

// The condition holds in the same cycle as the trigger.
`define BGB_ASSERT_NOW(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("glyph blitter assertion violated");

`endif

// File: rtl/bgb_pkg.sv
// Shared types and constants of the glyph blitter.
// No dependencies; used by the interfaces and every module but the port checker.
package bgb_pkg;

  localparam int ACTION_W = 2;
  localparam int CODE_W   = 8;
  localparam int TINDEX_W = 8;
  localparam int GADDR_W  = 14;
  localparam int PIXEL_W  = 32;
  localparam int POS_W    = 9;
  localparam int OADDR_W  = 16;
  localparam int SIZE_W   = 4;
  localparam int IMGW_W   = 12;
  localparam int AREA_W   = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [SIZE_W-1:0] GLYPH_W_RST = 4'd8;
  localparam logic [SIZE_W-1:0] GLYPH_H_RST = 4'd8;
  localparam logic [IMGW_W-1:0] IMAGE_W_RST = 12'd640;

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD_CODE  = 2'd0,
    ACT_LOAD_PIXEL = 2'd1,
    ACT_DRAW       = 2'd2
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GLYPH_W = 2'd0,
    CFG_GLYPH_H = 2'd1,
    CFG_IMAGE_W = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_SEARCH,
    BS_ALIGN,
    BS_EMIT
  } back_state_e;

  typedef struct packed {
    action_e             kind;
    logic [TINDEX_W-1:0] table_index;
    logic [CODE_W-1:0]   char_code;
    logic [GADDR_W-1:0]  glyph_address;
    logic [PIXEL_W-1:0]  pixel_value;
    logic [POS_W-1:0]    text_position;
  } cmd_t;

  // Glyph size already clamped, plus the pixel count of one glyph and the image width.
  typedef struct packed {
    logic [SIZE_W-1:0] gw;
    logic [SIZE_W-1:0] gh;
    logic [AREA_W-1:0] area;
    logic [IMGW_W-1:0] iw;
  } cfg_t;

endpackage

// File: rtl/bgb_in_if.sv
// Input item channel of the glyph blitter: valid/ready plus item fields.
// Depends on bgb_pkg for the field widths.
interface bgb_in_if;
  import bgb_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [TINDEX_W-1:0] table_index;
  logic [CODE_W-1:0]   char_code;
  logic [GADDR_W-1:0]  glyph_address;
  logic [PIXEL_W-1:0]  pixel_value;
  logic [POS_W-1:0]    text_position;

  modport source (output valid, action, table_index, char_code, glyph_address,
                  pixel_value, text_position, input ready);
  modport sink (input valid, action, table_index, char_code, glyph_address,
                pixel_value, text_position, output ready);
endinterface

// File: rtl/bgb_out_if.sv
// Output pixel channel of the glyph blitter: valid/ready plus pixel fields.
// Depends on bgb_pkg for the field widths.
interface bgb_out_if;
  import bgb_pkg::*;

  logic               valid;
  logic               ready;
  logic [OADDR_W-1:0] pixel_address;
  logic [PIXEL_W-1:0] pixel_color;
  logic               last;

  modport source (output valid, pixel_address, pixel_color, last, input ready);
  modport sink (input valid, pixel_address, pixel_color, last, output ready);
endinterface

// File: rtl/bgb_queue.sv
// Two-entry command queue between the front and back parts of the blitter.
// Depends on bgb_pkg for the command type.
module bgb_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bgb_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output bgb_pkg::cmd_t data_o,
  output logic          empty_o
);
  import bgb_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: rtl/bgb_front.sv
// Front part of the blitter: configuration registers, input acceptance and
// classification of items into queue commands. Depends on bgb_pkg, bgb_in_if.
module bgb_front #(
  parameter int TABLE_ENTRIES = 256,
  parameter int MAX_GLYPH_W   = 8,
  parameter int MAX_GLYPH_H   = 8,
  parameter int GLYPH_WORDS   = 16384
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bgb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bgb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  bgb_in_if.sink                         in_item,
  output bgb_pkg::cfg_t                  cfg_o,
  output logic                           push_o,
  output bgb_pkg::cmd_t                  cmd_o,
  input  logic                           full_i
);
  import bgb_pkg::*;

  localparam logic [SIZE_W-1:0] MAX_W = SIZE_W'(MAX_GLYPH_W);
  localparam logic [SIZE_W-1:0] MAX_H = SIZE_W'(MAX_GLYPH_H);

  logic [SIZE_W-1:0] gw_q, gh_q, gw_c, gh_c;
  logic [IMGW_W-1:0] iw_q;
  logic [2*SIZE_W-1:0] area_full;
  logic              accept, keep;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q <= GLYPH_W_RST;
      gh_q <= GLYPH_H_RST;
      iw_q <= IMAGE_W_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_GLYPH_W: gw_q <= cfg_data_i[SIZE_W-1:0];
        CFG_GLYPH_H: gh_q <= cfg_data_i[SIZE_W-1:0];
        CFG_IMAGE_W: iw_q <= cfg_data_i[IMGW_W-1:0];
        default: ;
      endcase
    end
  end

  // A zero size acts as one; oversized values saturate at the maximum.
  always_comb begin
    gw_c = (gw_q == '0) ? SIZE_W'(1) : ((gw_q > MAX_W) ? MAX_W : gw_q);
    gh_c = (gh_q == '0) ? SIZE_W'(1) : ((gh_q > MAX_H) ? MAX_H : gh_q);
  end

  assign area_full = {{SIZE_W{1'b0}}, gw_c} * {{SIZE_W{1'b0}}, gh_c};
  assign cfg_o.gw   = gw_c;
  assign cfg_o.gh   = gh_c;
  assign cfg_o.area = area_full[AREA_W-1:0];
  assign cfg_o.iw   = iw_q;

  assign in_item.ready = !full_i;
  assign accept        = in_item.valid && in_item.ready;

  // Out-of-range loads and the unused action are taken and dropped here.
  always_comb begin
    unique case (action_e'(in_item.action))
      ACT_LOAD_CODE:  keep = ({1'b0, in_item.table_index} < (TINDEX_W + 1)'(TABLE_ENTRIES));
      ACT_LOAD_PIXEL: keep = (17'(in_item.glyph_address) < 17'(GLYPH_WORDS));
      ACT_DRAW:       keep = 1'b1;
      default:        keep = 1'b0;
    endcase
  end

  assign push_o              = accept && keep;
  assign cmd_o.kind          = action_e'(in_item.action);
  assign cmd_o.table_index   = in_item.table_index;
  assign cmd_o.char_code     = in_item.char_code;
  assign cmd_o.glyph_address = in_item.glyph_address;
  assign cmd_o.pixel_value   = in_item.pixel_value;
  assign cmd_o.text_position = in_item.text_position;

endmodule

// File: rtl/bgb_back.sv
// Back part of the blitter: code table and glyph store, the table search,
// address alignment and the pixel emitter. Depends on bgb_pkg, bgb_out_if.
module bgb_back #(
  parameter int TABLE_ENTRIES = 256,
  parameter int GLYPH_WORDS   = 16384,
  parameter int OUT_PIXELS    = 65536
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  bgb_pkg::cfg_t cfg_i,
  input  bgb_pkg::cmd_t cmd_i,
  input  logic          empty_i,
  output logic          pop_o,
  bgb_out_if.source     out_pixel
);
  import bgb_pkg::*;

  localparam int TI_W = $clog2(TABLE_ENTRIES);
  localparam int GA_W = $clog2(GLYPH_WORDS);
  localparam int OA_W = $clog2(OUT_PIXELS);
  localparam int RW   = ((OA_W > IMGW_W) ? OA_W : IMGW_W) + 1;
  localparam int PP_W = POS_W + SIZE_W;

  localparam logic [TI_W-1:0] LAST_ENTRY = TI_W'(TABLE_ENTRIES - 1);
  localparam logic [GA_W:0]   GW_LIM     = (GA_W + 1)'(GLYPH_WORDS);
  localparam logic [GA_W-1:0] GW_TOP     = GA_W'(GLYPH_WORDS - 1);
  localparam logic [RW-1:0]   OP_LIM_R   = RW'(OUT_PIXELS);
  localparam logic [OA_W:0]   OP_LIM_A   = (OA_W + 1)'(OUT_PIXELS);
  localparam logic [OA_W-1:0] OP_TOP     = OA_W'(OUT_PIXELS - 1);

  logic [CODE_W-1:0]  code_mem  [TABLE_ENTRIES];
  logic [PIXEL_W-1:0] glyph_mem [GLYPH_WORDS];

  back_state_e        state_q, state_d;
  logic               cv_q, ovalid_q;
  logic [CODE_W-1:0]  code_q, tdata_q;
  logic [RW-1:0]      posr_q, iwr_q;
  logic [TI_W-1:0]    ra_q, e_q;
  logic [GA_W-1:0]    gb_q, src_q;
  logic [OA_W-1:0]    cur_q, rs_q;
  logic [SIZE_W-1:0]  row_q, col_q;
  logic [OADDR_W-1:0] oaddr_q;
  logic               olast_q;
  logic [PIXEL_W-1:0] gdata_q;

  logic            adv, hit, reduced, col_end, row_end, pix_last;
  logic            take, emit_go, code_we, glyph_we;
  logic [GA_W:0]   gb_sum;
  logic [GA_W-1:0] gb_next, src_inc;
  logic [OA_W:0]   rs_sum;
  logic [OA_W-1:0] rs_next, cur_inc;
  logic [PP_W-1:0] pos_prod;
  logic [16:0]     ga_ext;
  logic [20:0]     oa_ext;
  logic [RW-1:0]   posr_red, iwr_red;

  assign adv      = !ovalid_q || out_pixel.ready;
  assign hit      = cv_q && ((tdata_q == code_q) || (tdata_q == '0) || (e_q == LAST_ENTRY));
  assign reduced  = (posr_q < OP_LIM_R) && (iwr_q < OP_LIM_R);
  assign col_end  = (col_q == cfg_i.gw - SIZE_W'(1));
  assign row_end  = (row_q == cfg_i.gh - SIZE_W'(1));
  assign pix_last = col_end && row_end;

  // Glyph base of the entry under comparison, kept modulo the store size.
  assign gb_sum  = {1'b0, gb_q} + (GA_W + 1)'(cfg_i.area);
  assign gb_next = (gb_sum >= GW_LIM) ? GA_W'(gb_sum - GW_LIM) : gb_sum[GA_W-1:0];
  assign src_inc = (src_q == GW_TOP) ? '0 : src_q + 1'b1;

  // Output addresses advance by one per pixel and by the stride per row.
  assign rs_sum  = {1'b0, rs_q} + (OA_W + 1)'(iwr_q);
  assign rs_next = (rs_sum >= OP_LIM_A) ? OA_W'(rs_sum - OP_LIM_A) : rs_sum[OA_W-1:0];
  assign cur_inc = (cur_q == OP_TOP) ? '0 : cur_q + 1'b1;

  assign pos_prod = PP_W'(cmd_i.text_position) * PP_W'(cfg_i.gw);
  assign ga_ext   = 17'(cmd_i.glyph_address);
  assign oa_ext   = 21'(cur_q);
  assign posr_red = (posr_q >= OP_LIM_R) ? posr_q - OP_LIM_R : posr_q;
  assign iwr_red  = (iwr_q >= OP_LIM_R) ? iwr_q - OP_LIM_R : iwr_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BS_IDLE:   if (!empty_i && cmd_i.kind == ACT_DRAW) state_d = BS_SEARCH;
      BS_SEARCH: if (hit) state_d = BS_ALIGN;
      BS_ALIGN:  if (reduced) state_d = BS_EMIT;
      BS_EMIT:   if (adv && pix_last) state_d = BS_IDLE;
      default:   state_d = BS_IDLE;
    endcase
  end

  always_comb begin
    take     = (state_q == BS_IDLE) && !empty_i;
    code_we  = take && (cmd_i.kind == ACT_LOAD_CODE);
    glyph_we = take && (cmd_i.kind == ACT_LOAD_PIXEL);
    emit_go  = (state_q == BS_EMIT) && adv;
  end

  assign pop_o = take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BS_IDLE;
      cv_q     <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cv_q    <= (state_q == BS_SEARCH) && !hit;
      if (adv) begin
        ovalid_q <= emit_go;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      BS_IDLE: begin
        code_q <= cmd_i.char_code;
        posr_q <= RW'(pos_prod);
        iwr_q  <= RW'(cfg_i.iw);
        ra_q   <= '0;
        e_q    <= '0;
        gb_q   <= '0;
      end
      BS_SEARCH: begin
        // The read address runs one entry ahead of the compared entry.
        ra_q   <= (ra_q == LAST_ENTRY) ? ra_q : ra_q + 1'b1;
        posr_q <= posr_red;
        iwr_q  <= iwr_red;
        if (cv_q && !hit) begin
          e_q  <= e_q + 1'b1;
          gb_q <= gb_next;
        end
      end
      BS_ALIGN: begin
        posr_q <= posr_red;
        iwr_q  <= iwr_red;
        cur_q  <= posr_q[OA_W-1:0];
        rs_q   <= posr_q[OA_W-1:0];
        src_q  <= gb_q;
        row_q  <= '0;
        col_q  <= '0;
      end
      BS_EMIT: begin
        if (adv) begin
          oaddr_q <= oa_ext[OADDR_W-1:0];
          olast_q <= pix_last;
          src_q   <= src_inc;
          if (col_end) begin
            col_q <= '0;
            row_q <= row_q + 1'b1;
            cur_q <= rs_next;
            rs_q  <= rs_next;
          end else begin
            col_q <= col_q + 1'b1;
            cur_q <= cur_inc;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (code_we) begin
      code_mem[cmd_i.table_index[TI_W-1:0]] <= cmd_i.char_code;
    end
    if (state_q == BS_SEARCH) begin
      tdata_q <= code_mem[ra_q];
    end
  end

  // The store's read register doubles as the color half of the output register.
  always_ff @(posedge clk_i) begin
    if (glyph_we) begin
      glyph_mem[ga_ext[GA_W-1:0]] <= cmd_i.pixel_value;
    end
    if (emit_go) begin
      gdata_q <= glyph_mem[src_q];
    end
  end

  assign out_pixel.valid         = ovalid_q;
  assign out_pixel.pixel_address = oaddr_q;
  assign out_pixel.pixel_color   = gdata_q;
  assign out_pixel.last          = olast_q;

endmodule

// File: rtl/bitmap_glyph_blitter.sv
// Top level of the bitmap glyph blitter: front, command queue and back.
// Depends on bgb_pkg, bgb_in_if, bgb_out_if, bgb_front, bgb_queue, bgb_back.
//
//   channel     direction  transfer moves
//   in_item     sink       one load, draw or unused-action item
//   out_pixel   source     one glyph pixel with its image address
//   cfg_*       input      one register write, no handshake
//
// A load is popped and written while the back end is idle. A draw leaves the queue,
// then the table search runs (one entry per cycle through the code table's read port)
// to a match, a zero entry or the last entry; alignment brings start and stride below
// OUT_PIXELS (no subtraction at the default size); then the glyph_width*glyph_height
// glyph pixels are emitted, held while the output stalls, before the next command.
// The two-entry queue keeps taking items until it is full while the back end works or
// the output is stalled; the output holds its transfer until ready is seen.
// Reset clears control state only; both stores are undefined until loaded.
module bitmap_glyph_blitter #(
  parameter int TABLE_ENTRIES = 256,
  parameter int MAX_GLYPH_W   = 8,
  parameter int MAX_GLYPH_H   = 8,
  parameter int GLYPH_WORDS   = 16384,
  parameter int OUT_PIXELS    = 65536
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bgb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bgb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  bgb_in_if.sink                         in_item,
  bgb_out_if.source                      out_pixel
);
  import bgb_pkg::*;

  cfg_t cfg;
  cmd_t push_cmd, head_cmd;
  logic push, full, pop, empty;

  bgb_front #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .MAX_GLYPH_W  (MAX_GLYPH_W),
    .MAX_GLYPH_H  (MAX_GLYPH_H),
    .GLYPH_WORDS  (GLYPH_WORDS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_item   (in_item),
    .cfg_o     (cfg),
    .push_o    (push),
    .cmd_o     (push_cmd),
    .full_i    (full)
  );

  bgb_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_cmd),
    .full_o (full),
    .pop_i  (pop),
    .data_o (head_cmd),
    .empty_o(empty)
  );

  bgb_back #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .GLYPH_WORDS  (GLYPH_WORDS),
    .OUT_PIXELS   (OUT_PIXELS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .cmd_i    (head_cmd),
    .empty_i  (empty),
    .pop_o    (pop),
    .out_pixel(out_pixel)
  );

endmodule

// File: rtl/bgb_checker.sv
// Port-level checker of the glyph blitter, bound to the top level.
// Depends on bitmap_glyph_blitter_macros.svh and the top level's ports.
`include "bitmap_glyph_blitter_macros.svh"

module bgb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] out_pixel_address_i,
  input logic [31:0] out_pixel_color_i,
  input logic        out_last_i
);

  // A stalled pixel keeps its payload.
  `BGB_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_pixel_address_i) && $stable(out_pixel_color_i) && $stable(out_last_i))

  // Inside a glyph the emitter never leaves a gap after a transfer.
  `BGB_ASSERT_NEXT(a_glyph_burst, clk_i, rst_ni, out_valid_i && out_ready_i && !out_last_i, out_valid_i)

  // The queue can only fill up through an accepted item.
  `BGB_ASSERT_NOW(a_ready_drop, clk_i, rst_ni, $fell(in_ready_i), $past(in_valid_i && in_ready_i))

endmodule

bind bitmap_glyph_blitter bgb_checker u_bgb_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_item.valid),
  .in_ready_i         (in_item.ready),
  .out_valid_i        (out_pixel.valid),
  .out_ready_i        (out_pixel.ready),
  .out_pixel_address_i(out_pixel.pixel_address),
  .out_pixel_color_i  (out_pixel.pixel_color),
  .out_last_i         (out_pixel.last)
);

// File: tb/sv/bitmap_glyph_blitter_checker.sv
`timescale 1ns / 100ps
// Checker of the glyph blitter: watches both channels and the register port and
// predicts every glyph pixel. Depends on bgb_pkg, bgb_in_if and bgb_out_if.
module bitmap_glyph_blitter_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bgb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bgb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  bgb_in_if                              in_item,
  bgb_out_if                             out_pixel,
  output int                             fail_count_o,
  output int                             pending_o
);
  import bgb_pkg::*;

  localparam int TABLE_ENTRIES = 256;
  localparam int MAX_GLYPH_W   = 8;
  localparam int MAX_GLYPH_H   = 8;
  localparam int GLYPH_WORDS   = 16384;
  localparam int OUT_PIXELS    = 65536;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic [OADDR_W-1:0] addr;
    logic [PIXEL_W-1:0] color;
    logic               last;
  } glyph_pixel_t;

  logic [CODE_W-1:0]  code_table [TABLE_ENTRIES];
  logic [PIXEL_W-1:0] glyph_mem  [GLYPH_WORDS];
  logic [SIZE_W-1:0]  glyph_w;
  logic [SIZE_W-1:0]  glyph_h;
  logic [IMGW_W-1:0]  image_w;
  glyph_pixel_t       pixels_due [$];
  int                 n_fail = 0;

  // A zero size register acts as one; anything above the maximum saturates.
  function automatic int unsigned glyph_dim(logic [SIZE_W-1:0] reg_val,
                                            int unsigned max_dim);
    if (reg_val == '0) return 1;
    if (reg_val > max_dim) return max_dim;
    return reg_val;
  endfunction

  // The search stops at the first matching code or at the first zero entry, else at the last entry.
  function automatic int unsigned lookup_entry(logic [CODE_W-1:0] code);
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      if (code_table[k] == code || code_table[k] == '0) return k;
    end
    return TABLE_ENTRIES - 1;
  endfunction

  task automatic queue_glyph(input logic [CODE_W-1:0] code, input logic [POS_W-1:0] pos);
    int unsigned  gw;
    int unsigned  gh;
    int unsigned  entry;
    int unsigned  oaddr;
    int unsigned  src;
    glyph_pixel_t px;
    gw = glyph_dim(glyph_w, MAX_GLYPH_W);
    gh = glyph_dim(glyph_h, MAX_GLYPH_H);
    entry = lookup_entry(code);
    for (int unsigned row = 0; row < gh; row++) begin
      for (int unsigned col = 0; col < gw; col++) begin
        oaddr = row * image_w + pos * gw + col;
        src = gw * (entry * gh + row) + col;
        px.addr = OADDR_W'(oaddr % OUT_PIXELS);
        px.color = glyph_mem[src % GLYPH_WORDS];
        px.last = (row == gh - 1) && (col == gw - 1);
        pixels_due.push_back(px);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    glyph_pixel_t want;
    if (!rst_ni) begin
      glyph_w = GLYPH_W_RST;
      glyph_h = GLYPH_H_RST;
      image_w = IMAGE_W_RST;
      pixels_due.delete();
    end else begin
      // Results are checked before the new transfer is predicted, so a
      // stray pixel cannot be matched against a draw of the same edge.
      if (out_pixel.valid && out_pixel.ready) begin
        if (pixels_due.size() == 0) begin
          n_fail++;
          if (n_fail <= MAX_REPORTS)
            $display("%0t: unexpected pixel addr %h color %h last %b", $realtime,
                     out_pixel.pixel_address, out_pixel.pixel_color, out_pixel.last);
        end else begin
          want = pixels_due.pop_front();
          if (out_pixel.pixel_address !== want.addr || out_pixel.pixel_color !== want.color ||
              out_pixel.last !== want.last) begin
            n_fail++;
            if (n_fail <= MAX_REPORTS)
              $display("%0t: exp addr %h color %h last %b, got addr %h color %h last %b",
                       $realtime, want.addr, want.color, want.last, out_pixel.pixel_address,
                       out_pixel.pixel_color, out_pixel.last);
          end
        end
      end
      if (in_item.valid && in_item.ready) begin
        case (in_item.action)
          ACT_LOAD_CODE:  code_table[in_item.table_index] = in_item.char_code;
          ACT_LOAD_PIXEL: glyph_mem[in_item.glyph_address] = in_item.pixel_value;
          ACT_DRAW:       queue_glyph(in_item.char_code, in_item.text_position);
          default: ;
        endcase
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_GLYPH_W: glyph_w = cfg_data_i[SIZE_W-1:0];
          CFG_GLYPH_H: glyph_h = cfg_data_i[SIZE_W-1:0];
          CFG_IMAGE_W: image_w = cfg_data_i[IMGW_W-1:0];
          default: ;
        endcase
      end
    end
    fail_count_o <= n_fail;
    pending_o <= pixels_due.size();
  end

endmodule

// File: tb/sv/bitmap_glyph_blitter_tb.sv
`timescale 1ns / 100ps
// Top of the glyph blitter testbench: clock, reset, item and register stimulus.
// Depends on bgb_pkg, the two channel interfaces, the block and its checker.
module bitmap_glyph_blitter_tb;
  import bgb_pkg::*;

  localparam int TABLE_ENTRIES   = 256;
  localparam int GLYPH_LOADED    = 64;
  localparam int MAX_DIM         = 8;
  localparam int IDLE_PCT        = 13;
  localparam int SETTLE_CYCLES   = 20;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int PHASES          = 5;
  localparam int ITEMS_PER_PHASE = 5;
  localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  int                    fail_count;
  int                    pending;
  bit                    calm = 1'b0;
  int                    hold_cycles = 0;
  int                    draw_area;
  logic [CODE_W-1:0]     table_shadow [TABLE_ENTRIES];

  bgb_in_if  in_ch ();
  bgb_out_if out_ch ();

  bitmap_glyph_blitter i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_item    (in_ch),
    .out_pixel  (out_ch)
  );

  bitmap_glyph_blitter_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_item      (in_ch),
    .out_pixel    (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  // Output side: random stalls, calm stretches, and one long hold-off.
  initial begin : pixel_sink
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ch.ready <= 1'b0;
      end else if (calm) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Glyph size as the block sees it: zero acts as one, large values saturate.
  function automatic int clamp_dim(input logic [SIZE_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  // Entry 0 resolves to glyph words from 0 and the terminator in entry 1 to the
  // words after them, so a draw may miss entry 0 only while the glyph is small.
  function automatic logic [CODE_W-1:0] pick_code();
    if (draw_area <= GLYPH_LOADED / 2 && $urandom_range(1) == 1) return CODE_W'($urandom);
    return table_shadow[0];
  endfunction

  task automatic send_item(input logic [ACTION_W-1:0] act, input logic [TINDEX_W-1:0] tidx,
                           input logic [CODE_W-1:0] code, input logic [GADDR_W-1:0] gaddr,
                           input logic [PIXEL_W-1:0] pix, input logic [POS_W-1:0] pos);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.table_index <= tidx;
    in_ch.char_code <= code;
    in_ch.glyph_address <= gaddr;
    in_ch.pixel_value <= pix;
    in_ch.text_position <= pos;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  task automatic load_code(input int unsigned idx, input logic [CODE_W-1:0] code);
    table_shadow[idx] = code;
    send_item(ACT_LOAD_CODE, TINDEX_W'(idx), code, GADDR_W'($urandom), $urandom,
              POS_W'($urandom));
  endtask

  task automatic load_pixel(input logic [GADDR_W-1:0] addr, input logic [PIXEL_W-1:0] pix);
    send_item(ACT_LOAD_PIXEL, TINDEX_W'($urandom), CODE_W'($urandom), addr, pix,
              POS_W'($urandom));
  endtask

  task automatic draw_char(input logic [CODE_W-1:0] code, input logic [POS_W-1:0] pos);
    send_item(ACT_DRAW, TINDEX_W'($urandom), code, GADDR_W'($urandom), $urandom, pos);
  endtask

  // Stop offering items until every pixel has arrived, then let loads still
  // queued in the block drain out.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // The size registers take only their low bits, so the upper data bits are noise.
  task automatic set_config(input logic [SIZE_W-1:0] gw, input logic [SIZE_W-1:0] gh,
                            input logic [IMGW_W-1:0] iw);
    draw_area = clamp_dim(gw) * clamp_dim(gh);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_GLYPH_W;
    cfg_data_i <= {8'($urandom), gw};
    @(posedge clk_i);
    cfg_idx_i <= CFG_GLYPH_H;
    cfg_data_i <= {8'($urandom), gh};
    @(posedge clk_i);
    cfg_idx_i <= CFG_IMAGE_W;
    cfg_data_i <= iw;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin : stimulus
    logic [CODE_W-1:0] code;
    int unsigned       done;
    int unsigned       pick;
    in_ch.valid <= 1'b0;
    in_ch.action <= ACT_LOAD_CODE;
    in_ch.table_index <= '0;
    in_ch.char_code <= '0;
    in_ch.glyph_address <= '0;
    in_ch.pixel_value <= '0;
    in_ch.text_position <= '0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= CFG_GLYPH_W;
    cfg_data_i <= '0;
    draw_area = clamp_dim(GLYPH_W_RST) * clamp_dim(GLYPH_H_RST);
    rst_ni <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // One code ahead of the terminator; the search never compares an entry past entry 1.
    calm = 1'b1;
    load_code(0, CODE_W'($urandom_range(255, 1)));
    load_code(1, '0);
    // Every glyph word a draw can reach is loaded once before any draw.
    for (int a = 0; a < GLYPH_LOADED; a++) begin
      if (a == 0) load_pixel(GADDR_W'(a), 32'h0000_0000);
      else if (a == 1) load_pixel(GADDR_W'(a), 32'hFFFF_FFFF);
      else load_pixel(GADDR_W'(a), $urandom);
    end
    calm = 1'b0;

    draw_char(table_shadow[0], 9'd0);
    draw_char(table_shadow[0], 9'd511);
    send_item(ACT_SPARE, TINDEX_W'($urandom), CODE_W'($urandom), GADDR_W'($urandom),
              $urandom, POS_W'($urandom));
    load_pixel('0, 32'hA5A5_5A5A);
    draw_char(table_shadow[0], 9'd1);
    code = CODE_W'($urandom_range(255, 1));
    load_code(0, code);
    draw_char(code, 9'd42);
    load_code(5, CODE_W'($urandom));
    drain();
    set_config(4'd0, 4'd0, 12'd0);
    draw_char(table_shadow[0], 9'd511);
    draw_char('0, 9'd0);
    draw_char(table_shadow[0] ^ 8'h5A, 9'd17);
    drain();
    set_config(4'd15, 4'd15, 12'd4095);
    draw_char(table_shadow[0], 9'd511);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: set_config(4'd1, 4'd8, 12'd4095);
        1: set_config(4'd8, 4'd1, 12'd1);
        default: set_config(SIZE_W'($urandom_range(15)), SIZE_W'($urandom_range(15)),
                            IMGW_W'($urandom_range(4095)));
      endcase
      calm = (ph == 1);
      if (ph == 2) hold_cycles = HOLD_OFF_CYCLES;
      done = 0;
      while (done < ITEMS_PER_PHASE) begin
        // Only draws during the hold-off, so the queue fills and stalls the input.
        pick = (ph == 2) ? 0 : $urandom_range(99);
        if (pick < 55) begin
          draw_char(pick_code(), POS_W'($urandom));
          done++;
        end else if (pick < 72) begin
          load_pixel(GADDR_W'($urandom_range(GLYPH_LOADED - 1)), $urandom);
          done++;
        end else if (pick < 90) begin
          // Entry 1 stays the terminator; entries past it are never searched.
          if ($urandom_range(1) == 0) load_code(0, CODE_W'($urandom));
          else load_code($urandom_range(TABLE_ENTRIES - 1, 2), CODE_W'($urandom));
          done++;
        end else begin
          send_item(ACT_SPARE, TINDEX_W'($urandom), CODE_W'($urandom), GADDR_W'($urandom),
                    $urandom, POS_W'($urandom));
        end
      end
      drain();
      calm = 1'b0;
    end

    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/bgb_pkg.sv
rtl/bgb_in_if.sv
rtl/bgb_out_if.sv
rtl/bgb_queue.sv
rtl/bgb_front.sv
rtl/bgb_back.sv
rtl/bitmap_glyph_blitter.sv
rtl/bgb_checker.sv
tb/sv/bitmap_glyph_blitter_checker.sv
tb/sv/bitmap_glyph_blitter_tb.sv
